FILE: design/quat_to_rot6d_defines.svh
// ----------------------------------------------------------------------------
// Quaternion to 6D rotation: assertion macros
// Concurrent assertion forms used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef QUAT_TO_ROT6D_DEFINES_SVH
`define QUAT_TO_ROT6D_DEFINES_SVH

// Implication checked on every clock edge out of reset.
`define Q6D_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked out of reset.
`define Q6D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/q6d_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to 6D rotation package
// Widths and constants shared by the divider and the top level.
// ----------------------------------------------------------------------------
package q6d_pkg;

    localparam int FRAC_BITS = 14;
    // Numerator magnitudes are clamped to the denominator, which fits 33 bits.
    localparam int DEN_W     = 33;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int DIV_STEPS = QUO_W;
    localparam int ENTRIES   = 6;

    localparam logic [QUO_W-1:0] ONE_Q = QUO_W'(1) << FRAC_BITS;

    typedef logic [DEN_W-1:0] den_t;
    typedef logic [QUO_W-1:0] quo_t;

    // Saturate a magnitude and a sign to the 16-bit signed field.
    function automatic logic [15:0] q6d_pack(input quo_t q, input logic neg);
        logic [31:0] m;
        logic [31:0] lim;
        begin
            m   = 32'(q);
            lim = neg ? 32'd32768 : 32'd32767;
            if (m > lim) m = lim;
            q6d_pack = neg ? 16'(-m) : 16'(m);
        end
    endfunction

endpackage

FILE: design/q6d_divider.sv
// ----------------------------------------------------------------------------
// Quaternion to 6D rotation: pipelined restoring divider
// Computes round(mag * 2^FRAC_BITS / den) for mag <= den, one quotient bit
// per stage, so one division enters every cycle while en is high.
// ----------------------------------------------------------------------------
module q6d_divider (
    input  logic                  aclk,
    input  logic                  en,
    input  q6d_pkg::den_t         mag,
    input  q6d_pkg::den_t         den,
    output q6d_pkg::quo_t         quo
);

    localparam int S  = q6d_pkg::DIV_STEPS;
    localparam int RW = q6d_pkg::DEN_W + 1;

    logic [RW-1:0]            rem_reg [S+1];
    q6d_pkg::den_t            den_reg [S+1];
    q6d_pkg::quo_t            q_reg   [S+1];

    // Stage zero holds the operands. Rounding to nearest is applied after
    // the last step, from the final remainder.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= RW'(mag);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
        end
    end

    // One quotient bit per stage, top bit first; the remainder is doubled
    // before each compare but the first. The first step gives the integer bit.
    for (genvar i = 0; i < S; i++) begin : g_step
        logic [RW:0] trial;
        logic [RW:0] r2;
        always_comb begin
            r2    = (i == 0) ? {1'b0, rem_reg[i]} : {rem_reg[i], 1'b0};
            trial = r2 - {2'b00, den_reg[i]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[i+1] <= den_reg[i];
                if (!trial[RW]) begin
                    rem_reg[i+1] <= trial[RW-1:0];
                    q_reg[i+1]   <= {q_reg[i][q6d_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    rem_reg[i+1] <= r2[RW-1:0];
                    q_reg[i+1]   <= {q_reg[i][q6d_pkg::QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // Round half up: compare twice the final remainder with the divisor.
    always_comb begin
        logic [RW:0] r2f;
        r2f = {rem_reg[S], 1'b0};
        quo = q_reg[S] + q6d_pkg::QUO_W'(r2f >= {2'b00, den_reg[S]});
    end

endmodule

FILE: design/quat_to_rot6d.sv
// ----------------------------------------------------------------------------
// Quaternion to 6D rotation, top level
// Turns one Q1.14 quaternion into the first two rows of its rotation matrix.
// ----------------------------------------------------------------------------
// Use: an input word on s_axis carries qx, qy, qz, qw in tdata and the
// all_present flag in tuser. The result word on m_axis carries the six
// matrix entries r00, r01, r02, r10, r11, r12, saturated to +/-1.0 in Q1.14.
// The quaternion is normalized by its squared norm, so no root is taken;
// a zero quaternion or a cleared flag gives the identity rows.
// Throughput is one word per cycle unless stalled. There are 5 + DIV_STEPS = 20
// register stages: the input register, a product stage, a numerator stage,
// the divider operand stage, fifteen divider steps and the output register.
// The whole pipeline advances together; when m_axis_tready is low while
// a result waits, every stage holds and s_axis_tready drops, so nothing
// is lost or repeated. Empty stages are not filled while stalled.
// Reset clears the valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
module quat_to_rot6d (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // qx, qy, qz, qw (16 bits each)
    input  logic         s_axis_tuser,   // all_present
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata    // r00, r01, r02, r10, r11, r12
);

    `include "quat_to_rot6d_defines.svh"

    localparam int NST = 5 + q6d_pkg::DIV_STEPS; // valid-bit stages
    localparam int E   = q6d_pkg::ENTRIES;

    logic [NST-1:0] vld_reg;
    logic           en;

    // Advance whenever the output slot is free or being taken.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
        end
    end

    // Stage 1: register the inputs, with identity substituted when absent.
    logic signed [15:0] x_reg, y_reg, z_reg, w_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            if (s_axis_tuser) begin
                x_reg <= s_axis_tdata[15:0];
                y_reg <= s_axis_tdata[31:16];
                z_reg <= s_axis_tdata[47:32];
                w_reg <= s_axis_tdata[63:48];
            end else begin
                x_reg <= '0;
                y_reg <= '0;
                z_reg <= '0;
                w_reg <= 16'sd1;
            end
        end
    end

    // Stage 2: the ten products.
    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [31:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            zz_reg <= z_reg * z_reg;
            ww_reg <= w_reg * w_reg;
            xy_reg <= x_reg * y_reg;
            wz_reg <= w_reg * z_reg;
            xz_reg <= x_reg * z_reg;
            wy_reg <= w_reg * y_reg;
            yz_reg <= y_reg * z_reg;
            wx_reg <= w_reg * x_reg;
        end
    end

    // Stage 3: numerators and the squared norm; magnitudes clamp to it.
    logic signed [34:0] num [E];
    logic        [34:0] n2;
    always_comb begin
        n2     = 35'(xx_reg) + 35'(yy_reg) + 35'(zz_reg) + 35'(ww_reg);
        num[0] = 35'(ww_reg) + 35'(xx_reg) - 35'(yy_reg) - 35'(zz_reg);
        num[1] = (35'(xy_reg) - 35'(wz_reg)) <<< 1;
        num[2] = (35'(xz_reg) + 35'(wy_reg)) <<< 1;
        num[3] = (35'(xy_reg) + 35'(wz_reg)) <<< 1;
        num[4] = 35'(ww_reg) - 35'(xx_reg) + 35'(yy_reg) - 35'(zz_reg);
        num[5] = (35'(yz_reg) - 35'(wx_reg)) <<< 1;
    end

    q6d_pkg::den_t mag_reg [E];
    logic          neg_reg [E];
    q6d_pkg::den_t den_reg;
    logic          zero_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg  <= (n2 == '0) ? q6d_pkg::DEN_W'(1) : n2[q6d_pkg::DEN_W-1:0];
            zero_reg <= (n2 == '0);
            for (int k = 0; k < E; k++) begin
                logic [34:0] a;
                a = num[k][34] ? 35'(-num[k]) : 35'(num[k]);
                if (a > n2) a = n2;
                mag_reg[k] <= a[q6d_pkg::DEN_W-1:0];
                neg_reg[k] <= num[k][34];
            end
        end
    end

    // Six dividers run side by side; sign and zero flag ride alongside.
    q6d_pkg::quo_t quo [E];
    for (genvar k = 0; k < E; k++) begin : g_div
        q6d_divider u_div (
            .aclk (aclk),
            .en   (en),
            .mag  (mag_reg[k]),
            .den  (den_reg),
            .quo  (quo[k])
        );
    end

    logic [E:0] side_reg [q6d_pkg::DIV_STEPS+1];
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= {zero_reg, neg_reg[5], neg_reg[4], neg_reg[3],
                            neg_reg[2], neg_reg[1], neg_reg[0]};
            for (int i = 0; i < q6d_pkg::DIV_STEPS; i++) begin
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // Output register: saturate, or the identity rows for a zero norm.
    logic [95:0] out_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < E; k++) begin
                if (side_reg[q6d_pkg::DIV_STEPS][E]) begin
                    out_reg[16*k +: 16] <= (k == 0 || k == 4)
                        ? q6d_pkg::q6d_pack(q6d_pkg::ONE_Q, 1'b0) : 16'd0;
                end else begin
                    out_reg[16*k +: 16] <= q6d_pkg::q6d_pack(
                        quo[k] > q6d_pkg::ONE_Q ? q6d_pkg::ONE_Q : quo[k],
                        side_reg[q6d_pkg::DIV_STEPS][k]);
                end
            end
        end
    end
    assign m_axis_tdata = out_reg;

    `Q6D_ASSERT_IMPL(a_stall_holds, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
        "input accepted while output stalled")
    `Q6D_ASSERT_NEXT(a_stall_data, m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tdata) && m_axis_tvalid, "stalled output changed")
    `Q6D_ASSERT_IMPL(a_diag_pos, m_axis_tvalid, !m_axis_tdata[15] || !m_axis_tdata[79]
        || m_axis_tdata != '0, "both diagonal entries negative with zero word")

endmodule
